// ===== rtl/apbod_pkg.sv =====
// ----------------------------------------------------------------------------
// apbod_pkg: shared definitions for the all-pairs box overlap detector
// Command and status codes, fixed field widths and the per-slot control bundle.
// ----------------------------------------------------------------------------
package apbod_pkg;

	// fixed field widths of the command and result beats
	localparam int FUNC_W   = 2;
	localparam int INDEX_W  = 3;
	localparam int FIELD_W  = 16;
	localparam int SIZE_W   = 15;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 4;

	// command codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_APPEND  = 2'd0,
		FUNC_REMOVE  = 2'd1,
		FUNC_REWRITE = 2'd2,
		FUNC_POLL    = 2'd3
	} func_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_BAD_INDEX = 2'd2
	} status_t;

	// per-slot control: load from the command beat, or take the neighbor's box
	typedef struct packed {
		logic load;
		logic shift;
	} slot_ctl_t;

endpackage

// ===== rtl/all_pairs_box_overlap_detector.sv =====
// ----------------------------------------------------------------------------
// all_pairs_box_overlap_detector: ordered box table with all-pairs overlap poll
// A chain of box slots holds the table; a poll rotates the chain and reports
// every strictly overlapping active pair in lower-index-outer order.
// ----------------------------------------------------------------------------
// Append, remove and rewrite take effect in the cycle their command beat is
// accepted and return one registered result beat. A poll works through the
// stored boxes one lower index at a time: the slot comparators all check
// against the head of the chain, each hit then leaves as one result beat when
// the result register is free, and the chain rotates by a slot; the closing
// beat comes last. One rotation per stored box brings the table back to its
// stored order. One command is worked at a time, and a new command beat is
// taken once the previous result beats are issued and the result register is
// free or being emptied.
// ----------------------------------------------------------------------------
module all_pairs_box_overlap_detector #(
	parameter int MAX_BOXES   = 8,
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [apbod_pkg::FUNC_W-1:0]        func,
	input  logic [apbod_pkg::INDEX_W-1:0]       index,
	input  logic signed [apbod_pkg::FIELD_W-1:0] box_x,
	input  logic signed [apbod_pkg::FIELD_W-1:0] box_y,
	input  logic [apbod_pkg::SIZE_W-1:0]        box_width,
	input  logic [apbod_pkg::SIZE_W-1:0]        box_height,
	input  logic                                active,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [apbod_pkg::INDEX_W-1:0]       first_index,
	output logic [apbod_pkg::INDEX_W-1:0]       second_index,
	output logic                                pair_valid,
	output logic                                last,
	output logic [apbod_pkg::STATUS_W-1:0]      status,
	output logic [apbod_pkg::COUNT_W-1:0]       entry_count
);
	import apbod_pkg::*;

	localparam int IW    = $clog2(MAX_BOXES);
	localparam int CNTW  = $clog2(MAX_BOXES + 1);
	localparam int SUMW  = CNTW + 1;
	localparam int XW    = (CNTW > INDEX_W) ? CNTW : INDEX_W;
	localparam int BOX_W = 2 * COORD_WIDTH + 2 * SIZE_W + 1;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic [SIZE_W-1:0]             w;
		logic [SIZE_W-1:0]             h;
		logic                          act;
	} box_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOAD  = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_CLOSE = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [CNTW-1:0]        count_q;
	logic [IW-1:0]          iter_q;
	logic [MAX_BOXES-1:0]   mask_q;

	logic                   out_valid_q;
	logic [INDEX_W-1:0]     out_first_q;
	logic [INDEX_W-1:0]     out_second_q;
	logic                   out_pair_q;
	logic                   out_last_q;
	status_t                out_status_q;
	logic [COUNT_W-1:0]     out_count_q;

	func_t                  func_e;
	box_t                   new_box;
	logic                   in_fire;
	logic                   out_free;
	logic                   idx_ok;
	logic                   full;
	logic                   do_append;
	logic                   do_remove;
	logic                   do_rewrite;
	logic                   rotate;
	logic [CNTW-1:0]        count_nxt;
	status_t                cmd_status;
	logic                   pick_found;
	logic [IW-1:0]          pick_m;
	logic                   iter_done;
	logic [MAX_BOXES-1:0]   in_range;
	logic [MAX_BOXES-1:0]   hit_vec;

	slot_ctl_t              slot_ctl [MAX_BOXES];
	logic [BOX_W-1:0]       slot_box [MAX_BOXES];
	logic [BOX_W-1:0]       slot_next [MAX_BOXES];

	// command decode
	assign func_e    = func_t'(func);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign idx_ok    = XW'(index) < XW'(count_q);
	assign full      = count_q == CNTW'(MAX_BOXES);
	assign do_append  = in_fire && (func_e == FUNC_APPEND) && !full;
	assign do_remove  = in_fire && (func_e == FUNC_REMOVE) && idx_ok;
	assign do_rewrite = in_fire && (func_e == FUNC_REWRITE) && idx_ok;
	assign rotate     = (state_q == ST_EMIT) && !pick_found;
	assign iter_done  = (CNTW'(iter_q) + CNTW'(1)) == count_q;

	// box from the command beat
	always_comb begin
		new_box.x   = COORD_WIDTH'(box_x);
		new_box.y   = COORD_WIDTH'(box_y);
		new_box.w   = box_width;
		new_box.h   = box_height;
		new_box.act = active;
	end

	// count update and status of a table command
	always_comb begin
		count_nxt = count_q;
		if (do_append) begin
			count_nxt = count_q + CNTW'(1);
		end else if (do_remove) begin
			count_nxt = count_q - CNTW'(1);
		end
		unique case (func_e)
			FUNC_APPEND:  cmd_status = full ? STATUS_FULL : STATUS_OK;
			FUNC_REMOVE,
			FUNC_REWRITE: cmd_status = idx_ok ? STATUS_OK : STATUS_BAD_INDEX;
			FUNC_POLL:    cmd_status = STATUS_OK;
		endcase
	end

	// slot chain: controls, neighbor wiring and instances
	for (genvar k = 0; k < MAX_BOXES; k++) begin : g_slot
		always_comb begin
			slot_ctl[k].load = (do_append && (count_q == CNTW'(k))) ||
				(do_rewrite && (XW'(index) == XW'(k)));
			slot_ctl[k].shift = (do_remove && (XW'(k) >= XW'(index))) || rotate;
		end

		if (k == MAX_BOXES - 1) begin : g_wrap
			assign slot_next[k] = slot_box[0];
		end else begin : g_link
			assign slot_next[k] = (count_q == CNTW'(k + 1)) ? slot_box[0] : slot_box[k + 1];
		end

		apbod_box_slot #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_slot (
			.clk      (clk),
			.ctl      (slot_ctl[k]),
			.load_box (new_box),
			.next_box (slot_next[k]),
			.head_box (slot_box[0]),
			.box      (slot_box[k]),
			.hit      (hit_vec[k])
		);
	end

	// slots that hold a later box than the head
	always_comb begin
		for (int m = 0; m < MAX_BOXES; m++) begin
			in_range[m] = (m != 0) && ((SUMW'(iter_q) + SUMW'(m)) < SUMW'(count_q));
		end
	end

	// lowest pending hit
	always_comb begin
		pick_found = |mask_q;
		pick_m     = '0;
		for (int m = MAX_BOXES - 1; m >= 0; m--) begin
			if (mask_q[m]) begin
				pick_m = IW'(m);
			end
		end
	end

	// sequencer and table count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			iter_q  <= '0;
			mask_q  <= '0;
		end else begin
			count_q <= count_nxt;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (func_e == FUNC_POLL)) begin
						iter_q  <= '0;
						state_q <= (count_q == '0) ? ST_CLOSE : ST_LOAD;
					end
				end
				ST_LOAD: begin
					mask_q  <= hit_vec & in_range;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (pick_found) begin
						if (out_free) begin
							mask_q[pick_m] <= 1'b0;
						end
					end else if (iter_done) begin
						state_q <= ST_CLOSE;
					end else begin
						iter_q  <= iter_q + IW'(1);
						state_q <= ST_LOAD;
					end
				end
				ST_CLOSE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_fire && (func_e != FUNC_POLL)) ||
				((state_q == ST_EMIT) && pick_found && out_free) ||
				((state_q == ST_CLOSE) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (in_fire && (func_e != FUNC_POLL)) begin
			out_first_q  <= '0;
			out_second_q <= '0;
			out_pair_q   <= 1'b0;
			out_last_q   <= 1'b1;
			out_status_q <= cmd_status;
			out_count_q  <= COUNT_W'(count_nxt);
		end else if ((state_q == ST_EMIT) && pick_found && out_free) begin
			out_first_q  <= INDEX_W'(iter_q);
			out_second_q <= INDEX_W'(iter_q + pick_m);
			out_pair_q   <= 1'b1;
			out_last_q   <= 1'b0;
			out_status_q <= STATUS_OK;
			out_count_q  <= COUNT_W'(count_q);
		end else if ((state_q == ST_CLOSE) && out_free) begin
			out_first_q  <= '0;
			out_second_q <= '0;
			out_pair_q   <= 1'b0;
			out_last_q   <= 1'b1;
			out_status_q <= STATUS_OK;
			out_count_q  <= COUNT_W'(count_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign first_index  = out_first_q;
	assign second_index = out_second_q;
	assign pair_valid   = out_pair_q;
	assign last         = out_last_q;
	assign status       = out_status_q;
	assign entry_count  = out_count_q;

endmodule

// ===== rtl/apbod_box_slot.sv =====
// ----------------------------------------------------------------------------
// apbod_box_slot: one table slot of the box chain
// Holds one box, loads it from the command beat or takes the neighbor's box,
// and compares it against the head box of the chain for strict overlap.
// ----------------------------------------------------------------------------
module apbod_box_slot #(
	parameter int COORD_WIDTH = 16,
	localparam int BOX_W = 2 * COORD_WIDTH + 2 * apbod_pkg::SIZE_W + 1
) (
	input  logic                  clk,
	input  apbod_pkg::slot_ctl_t  ctl,
	input  logic [BOX_W-1:0]      load_box,
	input  logic [BOX_W-1:0]      next_box,
	input  logic [BOX_W-1:0]      head_box,
	output logic [BOX_W-1:0]      box,
	output logic                  hit
);
	import apbod_pkg::*;

	// sum width: wide enough that edge plus size never wraps
	localparam int SW = ((COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W) + 2;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic [SIZE_W-1:0]             w;
		logic [SIZE_W-1:0]             h;
		logic                          act;
	} box_t;

	box_t box_q;
	box_t head;

	logic signed [SW-1:0] ax, ay, aw, ah;
	logic signed [SW-1:0] bx, by, bw, bh;
	logic                 apart;

	// slot storage
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			box_q <= load_box;
		end else if (ctl.shift) begin
			box_q <= next_box;
		end
	end

	assign box  = box_q;
	assign head = head_box;

	// strict overlap against the head box
	always_comb begin
		ax = SW'(box_q.x);
		ay = SW'(box_q.y);
		aw = signed'(SW'(box_q.w));
		ah = signed'(SW'(box_q.h));
		bx = SW'(head.x);
		by = SW'(head.y);
		bw = signed'(SW'(head.w));
		bh = signed'(SW'(head.h));
		apart = (ax + aw <= bx) || (bx + bw <= ax) ||
			(ay + ah <= by) || (by + bh <= ay);
		hit = box_q.act && head.act && !apart;
	end

endmodule

// ===== bench/tb_all_pairs_box_overlap_detector.sv =====
// ----------------------------------------------------------------------------
// tb_all_pairs_box_overlap_detector: self-checking bench for the overlap detector
// Drives append, remove, rewrite and poll commands with random gaps on both
// sides, keeps its own copy of the box table and checks every result beat.
// ----------------------------------------------------------------------------
module tb_all_pairs_box_overlap_detector;
	import apbod_pkg::*;

	localparam int BOX_SLOTS   = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 60;
	localparam int RANDOM_CMDS = 405;

	// one stored box as the predictor keeps it
	typedef struct {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic [SIZE_W-1:0]         w;
		logic [SIZE_W-1:0]         h;
		logic                      act;
	} box_t;

	// one result beat
	typedef struct packed {
		logic [INDEX_W-1:0] first_idx;
		logic [INDEX_W-1:0] second_idx;
		logic               pair;
		logic               closing;
		status_t            st;
		logic [COUNT_W-1:0] count;
	} overlap_result_t;

	// box table model and queue of result beats still owed by the block
	class overlap_scoreboard;
		box_t            box_slots[BOX_SLOTS];
		int unsigned     box_count;
		overlap_result_t owed_results[$];
		int              failures;
		int              cmd_seen[4];
		int              pairs_seen;
		int              full_seen;
		int              bad_index_seen;

		function int pending_count();
			return owed_results.size();
		endfunction

		function bit boxes_overlap(box_t a, box_t b);
			int ax, ay, aw, ah, bx, by, bw, bh;
			ax = a.x; ay = a.y; aw = a.w; ah = a.h;
			bx = b.x; by = b.y; bw = b.w; bh = b.h;
			if (ax + aw <= bx) return 1'b0;
			if (bx + bw <= ax) return 1'b0;
			if (ay + ah <= by) return 1'b0;
			if (by + bh <= ay) return 1'b0;
			return 1'b1;
		endfunction

		function void push_result(int fi, int si, bit pv, bit closing, status_t st);
			overlap_result_t r;
			r.first_idx  = fi[INDEX_W-1:0];
			r.second_idx = si[INDEX_W-1:0];
			r.pair       = pv;
			r.closing    = closing;
			r.st         = st;
			r.count      = box_count[COUNT_W-1:0];
			owed_results.insert(owed_results.size(), r);
		endfunction

		// accepted command beat: update the table and queue its results
		function void note_command(func_t f, logic [INDEX_W-1:0] idx, box_t b);
			status_t st;
			st = STATUS_OK;
			cmd_seen[f]++;
			case (f)
				FUNC_POLL: begin
					for (int i = 0; i < box_count; i++)
						for (int j = i + 1; j < box_count; j++)
							if (box_slots[i].act && box_slots[j].act &&
							    boxes_overlap(box_slots[i], box_slots[j])) begin
								push_result(i, j, 1'b1, 1'b0, STATUS_OK);
								pairs_seen++;
							end
					push_result(0, 0, 1'b0, 1'b1, STATUS_OK);
					return;
				end
				FUNC_APPEND: begin
					if (box_count >= BOX_SLOTS) begin
						st = STATUS_FULL;
					end else begin
						box_slots[box_count] = b;
						box_count++;
					end
				end
				default: begin
					if (idx >= box_count) begin
						st = STATUS_BAD_INDEX;
					end else if (f == FUNC_REMOVE) begin
						for (int i = idx; i + 1 < box_count; i++)
							box_slots[i] = box_slots[i + 1];
						box_count--;
					end else begin
						box_slots[idx] = b;
					end
				end
			endcase
			if (st == STATUS_FULL) full_seen++;
			if (st == STATUS_BAD_INDEX) bad_index_seen++;
			push_result(0, 0, 1'b0, 1'b1, st);
		endfunction

		// accepted result beat: compare with the oldest owed result
		function void check_result(overlap_result_t got);
			overlap_result_t want;
			bit bad;
			if (owed_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result beat: fi=%0d si=%0d pv=%0d",
						got.first_idx, got.second_idx, got.pair,
						" last=%0d st=%0d cnt=%0d", got.closing, got.st, got.count);
				return;
			end
			want = owed_results.pop_front();
			bad = 1'b0;
			if (got.first_idx !== want.first_idx) bad = 1'b1;
			if (got.second_idx !== want.second_idx) bad = 1'b1;
			if (got.pair !== want.pair) bad = 1'b1;
			if (got.closing !== want.closing) bad = 1'b1;
			if (got.st !== want.st) bad = 1'b1;
			if (got.count !== want.count) bad = 1'b1;
			if (bad) begin
				failures++;
				if (failures <= 10)
					$display("result mismatch: expected fi=%0d si=%0d pv=%0d",
						want.first_idx, want.second_idx, want.pair,
						" last=%0d st=%0d cnt=%0d", want.closing, want.st, want.count,
						", got fi=%0d si=%0d pv=%0d",
						got.first_idx, got.second_idx, got.pair,
						" last=%0d st=%0d cnt=%0d", got.closing, got.st, got.count);
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [FUNC_W-1:0]          func = FUNC_APPEND;
	logic [INDEX_W-1:0]         index = '0;
	logic signed [FIELD_W-1:0]  box_x = '0;
	logic signed [FIELD_W-1:0]  box_y = '0;
	logic [SIZE_W-1:0]          box_width = '0;
	logic [SIZE_W-1:0]          box_height = '0;
	logic                       active = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [INDEX_W-1:0]         first_index;
	logic [INDEX_W-1:0]         second_index;
	logic                       pair_valid;
	logic                       last;
	logic [STATUS_W-1:0]        status;
	logic [COUNT_W-1:0]         entry_count;

	overlap_scoreboard sb = new();
	bit                burst_mode = 1'b0;
	int                cycle_count = 0;

	all_pairs_box_overlap_detector #(
		.MAX_BOXES  (BOX_SLOTS),
		.COORD_WIDTH(FIELD_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.index       (index),
		.box_x       (box_x),
		.box_y       (box_y),
		.box_width   (box_width),
		.box_height  (box_height),
		.active      (active),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.first_index (first_index),
		.second_index(second_index),
		.pair_valid  (pair_valid),
		.last        (last),
		.status      (status),
		.entry_count (entry_count)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("all_pairs_box_overlap_detector: mismatch");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		overlap_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.first_idx  = first_index;
			got.second_idx = second_index;
			got.pair       = pair_valid;
			got.closing    = last;
			got.st         = status_t'(status);
			got.count      = entry_count;
			sb.check_result(got);
		end
	end

	function int draw_gap();
		return burst_mode ? 0 : $urandom_range(0, 10);
	endfunction

	// result side: random stall before each beat
	initial begin : result_sink
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// send one command beat and record it once accepted
	task automatic issue_command(func_t f, logic [INDEX_W-1:0] idx, box_t b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		index      <= idx;
		box_x      <= b.x;
		box_y      <= b.y;
		box_width  <= b.w;
		box_height <= b.h;
		active     <= b.act;
		do @(posedge clk); while (!in_ready);
		sb.note_command(f, idx, b);
	endtask

	// hold off the sender until every owed result has arrived
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_count() != 0) @(posedge clk);
	endtask

	function box_t make_box(int x, int y, int w, int h, bit act);
		box_t b;
		b.x   = x[FIELD_W-1:0];
		b.y   = y[FIELD_W-1:0];
		b.w   = w[SIZE_W-1:0];
		b.h   = h[SIZE_W-1:0];
		b.act = act;
		return b;
	endfunction

	// mostly clustered boxes so that polls find pairs, some near the extremes
	function box_t random_box();
		int kind;
		box_t b;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			b = make_box(int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 400)) - 200,
				$urandom_range(0, 300), $urandom_range(0, 300), $urandom_range(0, 99) < 80);
		end else if (kind < 85) begin
			b = make_box($urandom_range(0, 1) ? -32768 + int'($urandom_range(0, 100))
			                                  : 32767 - int'($urandom_range(0, 100)),
				$urandom_range(0, 1) ? -32768 + int'($urandom_range(0, 100))
				                     : 32767 - int'($urandom_range(0, 100)),
				$urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 100))
				                     : int'($urandom_range(0, 100)),
				$urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 100))
				                     : int'($urandom_range(0, 100)),
				$urandom_range(0, 99) < 80);
		end else begin
			b.x   = FIELD_W'($urandom());
			b.y   = FIELD_W'($urandom());
			b.w   = SIZE_W'($urandom());
			b.h   = SIZE_W'($urandom());
			b.act = 1'($urandom_range(0, 1));
		end
		return b;
	endfunction

	// stimulus
	initial begin : stimulus
		box_t             none;
		func_t            f;
		int               pick;
		logic [INDEX_W-1:0] idx;

		none = make_box(0, 0, 0, 0, 1'b0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, touching and overlapping boxes, full table, bad indexes
		issue_command(FUNC_POLL, 3'd0, none);
		issue_command(FUNC_REMOVE, 3'd0, none);
		issue_command(FUNC_REWRITE, 3'd3, none);
		issue_command(FUNC_APPEND, 3'd0, make_box(-32768, -32768, 32767, 32767, 1'b1));
		issue_command(FUNC_APPEND, 3'd0, make_box(-1, -1, 1, 1, 1'b1));
		issue_command(FUNC_APPEND, 3'd0, make_box(-2, -2, 2, 2, 1'b1));
		issue_command(FUNC_APPEND, 3'd0, make_box(32767, 32767, 32767, 32767, 1'b1));
		issue_command(FUNC_APPEND, 3'd0, make_box(0, 0, 0, 0, 1'b1));
		issue_command(FUNC_APPEND, 3'd0, make_box(-100, -100, 32767, 32767, 1'b0));
		issue_command(FUNC_APPEND, 3'd0, make_box(32760, 32760, 10, 10, 1'b1));
		issue_command(FUNC_APPEND, 3'd0, make_box(-5, -5, 32767, 32767, 1'b1));
		issue_command(FUNC_APPEND, 3'd7, make_box(1, 1, 5, 5, 1'b1));
		issue_command(FUNC_POLL, 3'd0, none);
		issue_command(FUNC_REWRITE, 3'd5, make_box(-100, -100, 32767, 32767, 1'b1));
		issue_command(FUNC_POLL, 3'd0, none);
		issue_command(FUNC_REMOVE, 3'd0, none);
		issue_command(FUNC_REMOVE, 3'd6, none);
		issue_command(FUNC_REMOVE, 3'd6, none);
		issue_command(FUNC_REWRITE, 3'd7, make_box(3, 3, 3, 3, 1'b1));
		issue_command(FUNC_POLL, 3'd0, none);
		repeat (6) issue_command(FUNC_REMOVE, 3'd0, none);
		issue_command(FUNC_POLL, 3'd0, none);
		wait_drained();

		// random commands, steered by the current fill level
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
			if (n % 70 == 69) wait_drained();
			pick = $urandom_range(0, 99);
			if (sb.box_count < 3)
				f = (pick < 60) ? FUNC_APPEND : (pick < 72) ? FUNC_REMOVE :
				    (pick < 84) ? FUNC_REWRITE : FUNC_POLL;
			else if (sb.box_count == BOX_SLOTS)
				f = (pick < 15) ? FUNC_APPEND : (pick < 45) ? FUNC_REMOVE :
				    (pick < 65) ? FUNC_REWRITE : FUNC_POLL;
			else
				f = (pick < 35) ? FUNC_APPEND : (pick < 55) ? FUNC_REMOVE :
				    (pick < 75) ? FUNC_REWRITE : FUNC_POLL;
			if (sb.box_count > 0 && $urandom_range(0, 99) < 80)
				idx = INDEX_W'($urandom_range(0, sb.box_count - 1));
			else
				idx = INDEX_W'($urandom_range(0, 7));
			issue_command(f, idx, random_box());
		end

		// wind down
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d appends, %0d removes, %0d rewrites, %0d polls",
			sb.cmd_seen[FUNC_APPEND], sb.cmd_seen[FUNC_REMOVE],
			sb.cmd_seen[FUNC_REWRITE], sb.cmd_seen[FUNC_POLL]);
		$display("%0d overlapping pairs reported, %0d full-table and %0d bad-index rejects",
			sb.pairs_seen, sb.full_seen, sb.bad_index_seen);
		if (sb.failures == 0 && sb.pending_count() == 0) begin
			$display("all_pairs_box_overlap_detector: match");
		end else begin
			$display("%0d failures, %0d results still owed", sb.failures, sb.pending_count());
			$display("all_pairs_box_overlap_detector: mismatch");
		end
		$finish;
	end

endmodule

// ===== all_pairs_box_overlap_detector.f =====
rtl/apbod_pkg.sv
rtl/apbod_box_slot.sv
rtl/all_pairs_box_overlap_detector.sv
bench/tb_all_pairs_box_overlap_detector.sv
